>>> hdl/trapint_pkg.sv
// shared types, constants and coefficient tables of the trapezoid integrator
package trapint_pkg;

    localparam int FRAC_BITS = 24;
    localparam int IQ = 30;
    localparam int XQ_SHIFT = IQ - FRAC_BITS;

    localparam logic signed [34:0] PI_Q      = 35'sd3373259426;
    localparam logic signed [34:0] HALF_PI_Q = 35'sd1686629713;
    localparam logic signed [34:0] TWO_PI_Q  = 35'sd6746518852;
    localparam logic signed [34:0] CORDIC_GAIN = 35'sd652032874;
    localparam logic [34:0] LN2_Q = 35'd744261118;
    localparam logic [47:0] EXP_LIMIT = 48'd23072094658;
    localparam logic [31:0] INV_SQRT_2PI_Q = 32'd428361012;
    localparam logic [47:0] ONE_Q = 48'd1 << IQ;
    localparam logic signed [48:0] ACC_MAX = (49'sd1 <<< 47) - 49'sd1;
    localparam logic signed [47:0] OUT_MAX = 48'sd2147483647;
    localparam logic signed [47:0] OUT_MIN = -48'sd2147483648;
    localparam logic [1:0] NUM_INTEGRANDS = 2'd3;
    localparam logic [1:0] SEL_SINE  = 2'd0;
    localparam logic [1:0] SEL_GAUSS = 2'd1;

    typedef enum logic [4:0] {
        ST_IDLE, ST_CHECK, ST_DIV, ST_DIV_FIX, ST_EVAL, ST_RED, ST_RED_FIX,
        ST_CORDIC, ST_SINE_OUT, ST_GAUSS_SQ, ST_GAUSS_T, ST_DECAY_T,
        ST_EXP_INIT, ST_EXP_K, ST_EXP_PREP, ST_EXP_LOOP, ST_EXP_OUT,
        ST_GAUSS_SCALE, ST_GAUSS_OUT, ST_DECAY_OUT, ST_POST, ST_TERM_LO,
        ST_TERM_HI, ST_TERM_ACC, ST_FINAL, ST_REPORT
    } state_t;

    typedef enum logic [4:0] {
        CMD_NONE, CMD_LOAD, CMD_CHECK, CMD_DIV_STEP, CMD_DIV_FIX, CMD_EVAL,
        CMD_RED_STEP, CMD_RED_FIX, CMD_CORDIC, CMD_SINE_OUT, CMD_GAUSS_SQ,
        CMD_GAUSS_T, CMD_DECAY_T, CMD_EXP_INIT, CMD_EXP_K, CMD_EXP_PREP,
        CMD_EXP_LOOP, CMD_EXP_OUT, CMD_GAUSS_SCALE, CMD_GAUSS_OUT,
        CMD_DECAY_OUT, CMD_POST, CMD_TERM_LO, CMD_TERM_HI, CMD_TERM_ACC,
        CMD_FINAL
    } cmd_t;

    typedef struct packed {
        logic       bad_sel;
        logic       zero_n;
        logic       div_last;
        logic       red_last;
        logic       cordic_last;
        logic       exp_big;
        logic       k_last;
        logic       exp_exit;
        logic       gauss_far;
        logic       x_neg;
        logic       first;
        logic       slice_last;
        logic [1:0] sel;
    } status_t;

    function automatic logic [31:0] atan_val(input logic [4:0] idx);
        logic [31:0] v;
        unique case (idx)
            5'd0:  v = 32'h3243F6A8;
            5'd1:  v = 32'h1DAC6705;
            5'd2:  v = 32'h0FADBAFC;
            5'd3:  v = 32'h07F56EA6;
            5'd4:  v = 32'h03FEAB76;
            5'd5:  v = 32'h01FFD55B;
            5'd6:  v = 32'h00FFFAAA;
            5'd7:  v = 32'h007FFF55;
            5'd8:  v = 32'h003FFFEA;
            5'd9:  v = 32'h001FFFFD;
            5'd10: v = 32'h000FFFFF;
            5'd11: v = 32'h0007FFFF;
            5'd12: v = 32'h0003FFFF;
            5'd13: v = 32'h0001FFFF;
            5'd14: v = 32'h0000FFFF;
            5'd15: v = 32'h00007FFF;
            5'd16: v = 32'h00003FFF;
            5'd17: v = 32'h00001FFF;
            5'd18: v = 32'h00000FFF;
            5'd19: v = 32'h000007FF;
            5'd20: v = 32'h000003FF;
            5'd21: v = 32'h000001FF;
            5'd22: v = 32'h000000FF;
            5'd23: v = 32'h0000007F;
            5'd24: v = 32'h0000003F;
            5'd25: v = 32'h0000001F;
            5'd26: v = 32'h0000000F;
            5'd27: v = 32'h00000008;
            5'd28: v = 32'h00000004;
            5'd29: v = 32'h00000002;
            5'd30: v = 32'h00000001;
            default: v = 32'h0;
        endcase
        return v;
    endfunction

    // ln(1 + 2^-i) with 30 fraction bits
    function automatic logic [30:0] ln_val(input logic [4:0] idx);
        logic [30:0] v;
        unique case (idx)
            5'd1:  v = 31'd435364845;
            5'd2:  v = 31'd239598564;
            5'd3:  v = 31'd126468572;
            5'd4:  v = 31'd65095192;
            5'd5:  v = 31'd33040817;
            5'd6:  v = 31'd16647494;
            5'd7:  v = 31'd8356010;
            5'd8:  v = 31'd4186133;
            5'd9:  v = 31'd2095107;
            5'd10: v = 31'd1048064;
            5'd11: v = 31'd524160;
            5'd12: v = 31'd262112;
            5'd13: v = 31'd131064;
            5'd14: v = 31'd65534;
            5'd15: v = 31'd32768;
            5'd0:  v = 31'd0;
            default: v = 31'd1 << (5'd30 - idx);
        endcase
        return v;
    endfunction

endpackage

>>> hdl/trapezoid_integrator_core.sv
// top level of the trapezoid integrator: controller plus datapath
// one item at a time; busy is high from the accepting edge through the done cycle
// a zero step count or a bad selector goes from the check straight to the report;
// the exponential integrands take a data-dependent time in the shift-add loop,
// and an early-zero sample skips the evaluation; the next item is taken after done
// done pulses one cycle, the receiver cannot stall; async reset returns to idle
module trapezoid_integrator_core (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    output logic               done,
    input  logic signed [15:0] range_start,
    input  logic signed [15:0] range_end,
    input  logic [15:0]        step_count,
    input  logic [1:0]         func_select,
    output logic signed [31:0] area,
    output logic               saturated,
    output logic               bad_select
);
    import trapint_pkg::*;

    cmd_t    cmd;
    status_t status;

    trapint_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .cmd    (cmd),
        .busy   (busy),
        .done   (done)
    );

    trapint_dp u_dp (
        .clk         (clk),
        .cmd         (cmd),
        .range_start (range_start),
        .range_end   (range_end),
        .step_count  (step_count),
        .func_select (func_select),
        .status      (status),
        .area        (area),
        .saturated   (saturated),
        .bad_select  (bad_select)
    );

endmodule

>>> hdl/trapint_ctrl.sv
// sequencing state machine of the trapezoid integrator
module trapint_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  trapint_pkg::status_t  status,
    output trapint_pkg::cmd_t     cmd,
    output logic                  busy,
    output logic                  done
);
    import trapint_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:        if (start) state_next = ST_CHECK;
            ST_CHECK:
            begin
                if (status.bad_sel || status.zero_n)
                    state_next = ST_REPORT;
                else
                    state_next = ST_DIV;
            end
            ST_DIV:         if (status.div_last) state_next = ST_DIV_FIX;
            ST_DIV_FIX:     state_next = ST_EVAL;
            ST_EVAL:
            begin
                if (status.sel == SEL_SINE)
                    state_next = ST_RED;
                else if (status.sel == SEL_GAUSS)
                    state_next = status.gauss_far ? ST_POST : ST_GAUSS_SQ;
                else
                    state_next = status.x_neg ? ST_POST : ST_DECAY_T;
            end
            ST_RED:         if (status.red_last) state_next = ST_RED_FIX;
            ST_RED_FIX:     state_next = ST_CORDIC;
            ST_CORDIC:      if (status.cordic_last) state_next = ST_SINE_OUT;
            ST_SINE_OUT:    state_next = ST_POST;
            ST_GAUSS_SQ:    state_next = ST_GAUSS_T;
            ST_GAUSS_T:     state_next = ST_EXP_INIT;
            ST_DECAY_T:     state_next = ST_EXP_INIT;
            ST_EXP_INIT:
            begin
                if (!status.exp_big)
                    state_next = ST_EXP_K;
                else if (status.sel == SEL_GAUSS)
                    state_next = ST_GAUSS_SCALE;
                else
                    state_next = ST_DECAY_OUT;
            end
            ST_EXP_K:       if (status.k_last) state_next = ST_EXP_PREP;
            ST_EXP_PREP:    state_next = ST_EXP_LOOP;
            ST_EXP_LOOP:    if (status.exp_exit) state_next = ST_EXP_OUT;
            ST_EXP_OUT:
            begin
                state_next = (status.sel == SEL_GAUSS) ? ST_GAUSS_SCALE : ST_DECAY_OUT;
            end
            ST_GAUSS_SCALE: state_next = ST_GAUSS_OUT;
            ST_GAUSS_OUT:   state_next = ST_POST;
            ST_DECAY_OUT:   state_next = ST_POST;
            ST_POST:        state_next = status.first ? ST_EVAL : ST_TERM_LO;
            ST_TERM_LO:     state_next = ST_TERM_HI;
            ST_TERM_HI:     state_next = ST_TERM_ACC;
            ST_TERM_ACC:    state_next = status.slice_last ? ST_FINAL : ST_EVAL;
            ST_FINAL:       state_next = ST_REPORT;
            ST_REPORT:      state_next = ST_IDLE;
            default:        state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd  = CMD_NONE;
        busy = 1'b1;
        done = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                busy = 1'b0;
                cmd  = start ? CMD_LOAD : CMD_NONE;
            end
            ST_CHECK:       cmd = CMD_CHECK;
            ST_DIV:         cmd = CMD_DIV_STEP;
            ST_DIV_FIX:     cmd = CMD_DIV_FIX;
            ST_EVAL:        cmd = CMD_EVAL;
            ST_RED:         cmd = CMD_RED_STEP;
            ST_RED_FIX:     cmd = CMD_RED_FIX;
            ST_CORDIC:      cmd = CMD_CORDIC;
            ST_SINE_OUT:    cmd = CMD_SINE_OUT;
            ST_GAUSS_SQ:    cmd = CMD_GAUSS_SQ;
            ST_GAUSS_T:     cmd = CMD_GAUSS_T;
            ST_DECAY_T:     cmd = CMD_DECAY_T;
            ST_EXP_INIT:    cmd = CMD_EXP_INIT;
            ST_EXP_K:       cmd = CMD_EXP_K;
            ST_EXP_PREP:    cmd = CMD_EXP_PREP;
            ST_EXP_LOOP:    cmd = CMD_EXP_LOOP;
            ST_EXP_OUT:     cmd = CMD_EXP_OUT;
            ST_GAUSS_SCALE: cmd = CMD_GAUSS_SCALE;
            ST_GAUSS_OUT:   cmd = CMD_GAUSS_OUT;
            ST_DECAY_OUT:   cmd = CMD_DECAY_OUT;
            ST_POST:        cmd = CMD_POST;
            ST_TERM_LO:     cmd = CMD_TERM_LO;
            ST_TERM_HI:     cmd = CMD_TERM_HI;
            ST_TERM_ACC:    cmd = CMD_TERM_ACC;
            ST_FINAL:       cmd = CMD_FINAL;
            ST_REPORT:      done = 1'b1;
            default:        cmd = CMD_NONE;
        endcase
    end

endmodule

>>> hdl/trapint_dp.sv
// datapath: divider, range reduction, cordic, shift-add exponential, accumulator
module trapint_dp (
    input  logic                  clk,
    input  trapint_pkg::cmd_t     cmd,
    input  logic signed [15:0]    range_start,
    input  logic signed [15:0]    range_end,
    input  logic [15:0]           step_count,
    input  logic [1:0]            func_select,
    output trapint_pkg::status_t  status,
    output logic signed [31:0]    area,
    output logic                  saturated,
    output logic                  bad_select
);
    import trapint_pkg::*;

    logic signed [15:0] rs_reg, re_reg;
    logic [15:0]        n_reg;
    logic [1:0]         sel_reg;
    logic [39:0]        quo_reg;
    logic [15:0]        drem_reg;
    logic [5:0]         dcnt_reg;
    logic               dneg_reg;
    logic signed [40:0] dx_reg;
    logic signed [41:0] x_reg;
    logic [47:0]        red_reg;
    logic [3:0]         rcnt_reg;
    logic signed [34:0] cx_reg, cy_reg, z_reg;
    logic [4:0]         ci_reg;
    logic [47:0]        t_reg;
    logic [34:0]        kr_reg;
    logic [4:0]         k_reg;
    logic [2:0]         kb_reg;
    logic [30:0]        u_reg;
    logic [32:0]        y_reg;
    logic [4:0]         ei_reg;
    logic [30:0]        e_reg;
    logic [63:0]        prod_reg;
    logic [38:0]        lo_reg;
    logic signed [34:0] v_reg;
    logic signed [25:0] samp_reg, left_reg;
    logic               first_reg;
    logic signed [47:0] acc_reg;
    logic [15:0]        cnt_reg;
    logic               sat_reg;
    logic signed [31:0] area_reg;
    logic               bad_reg;

    logic signed [16:0] diff_s;
    logic [15:0]        diff_mag;
    logic [16:0]        div_trial;
    logic               div_ge;
    logic [16:0]        div_sub;
    logic signed [47:0] xq;
    logic [47:0]        xabs;
    logic [48:0]        red_cmp;
    logic               red_ge;
    logic [32:0]        red_m;
    logic signed [34:0] r0, r1, rf;
    logic signed [34:0] sx, sy, at;
    logic [34:0]        k_cmp;
    logic [30:0]        ln_i;
    logic               fit;
    logic [33:0]        e_round;
    logic [47:0]        t_decay;
    logic               lt_one;
    logic [31:0]        mul_a, mul_b;
    logic               vneg;
    logic [34:0]        vabs, vrnd;
    logic [24:0]        smag;
    logic signed [25:0] samp;
    logic signed [26:0] psum;
    logic [26:0]        us;
    logic [40:0]        ua;
    logic               tneg;
    logic [43:0]        mag;
    logic signed [48:0] term, accs;
    logic signed [47:0] acc_sat;
    logic               acc_clip;
    logic [63:0]        gauss_rnd;

    function automatic logic signed [16:0] range_end_ext(input logic signed [15:0] v);
        return {v[15], v};
    endfunction

    assign diff_s    = {range_end_ext(re_reg)} - {range_end_ext(rs_reg)};
    assign diff_mag  = diff_s[16] ? 16'(-diff_s) : diff_s[15:0];
    assign div_trial = {drem_reg, quo_reg[39]};
    assign div_ge    = div_trial >= {1'b0, n_reg};
    assign div_sub   = div_trial - {1'b0, n_reg};

    assign xq   = {x_reg, {XQ_SHIFT{1'b0}}};
    assign xabs = x_reg[41] ? 48'(-xq) : 48'(xq);

    // x mod 2*pi, one shifted modulus per cycle
    assign red_cmp = {14'd0, TWO_PI_Q} << rcnt_reg;
    assign red_ge  = {1'b0, red_reg} >= red_cmp;
    assign red_m   = red_reg[32:0];
    assign r0 = (x_reg[41] && red_m != 33'd0) ? TWO_PI_Q - $signed({2'b0, red_m})
                                               : $signed({2'b0, red_m});
    assign r1 = (r0 > PI_Q) ? r0 - TWO_PI_Q : r0;
    assign rf = (r1 > HALF_PI_Q) ? PI_Q - r1 : ((r1 < -HALF_PI_Q) ? -PI_Q - r1 : r1);

    assign sx = cx_reg >>> ci_reg;
    assign sy = cy_reg >>> ci_reg;
    assign at = $signed({3'b0, atan_val(ci_reg)});

    assign k_cmp   = LN2_Q << kb_reg;
    assign ln_i    = ln_val(ei_reg);
    assign fit     = u_reg >= ln_i;
    assign e_round = ({1'b0, y_reg} + (34'd1 << k_reg)) >> ({1'b0, k_reg} + 6'd1);

    assign lt_one  = xabs[47:IQ] == '0;
    assign t_decay = lt_one ? ({16'd0, xabs[29:0], 2'b0} + {18'd0, xabs[29:0]})
                            : xabs - ONE_Q;

    assign psum = 27'(left_reg) + 27'(samp_reg);
    assign us   = psum[26] ? 27'(-psum) : 27'(psum);
    assign ua   = dx_reg[40] ? 41'(-dx_reg) : 41'(dx_reg);
    assign tneg = dx_reg[40] ^ psum[26];

    always_comb
    begin
        mul_a = 32'd0;
        mul_b = 32'd0;
        case (cmd)
            CMD_GAUSS_SQ:
            begin
                mul_a = {2'b0, xabs[33:4]};
                mul_b = {2'b0, xabs[33:4]};
            end
            CMD_GAUSS_SCALE:
            begin
                mul_a = {1'b0, e_reg};
                mul_b = INV_SQRT_2PI_Q;
            end
            CMD_TERM_LO:
            begin
                mul_a = ua[31:0];
                mul_b = {5'd0, us};
            end
            CMD_TERM_HI:
            begin
                mul_a = {23'd0, ua[40:32]};
                mul_b = {5'd0, us};
            end
            default:
            begin
                mul_a = 32'd0;
                mul_b = 32'd0;
            end
        endcase
    end

    assign gauss_rnd = prod_reg + (64'd1 << (IQ - 1));

    // round half away from zero to output precision, then clamp to +-1
    assign vneg = v_reg[34];
    assign vabs = vneg ? 35'(-v_reg) : 35'(v_reg);
    assign vrnd = (vabs + (35'd1 << (XQ_SHIFT - 1))) >> XQ_SHIFT;
    assign smag = (vrnd > (35'd1 << FRAC_BITS)) ? (25'd1 << FRAC_BITS) : vrnd[24:0];
    assign samp = vneg ? -$signed({1'b0, smag}) : $signed({1'b0, smag});

    assign mag  = {prod_reg[36:0], 7'd0} + {5'd0, lo_reg};
    assign term = tneg ? -$signed({5'd0, mag}) : $signed({5'd0, mag});
    assign accs = {acc_reg[47], acc_reg} + term;

    always_comb
    begin
        acc_clip = 1'b0;
        acc_sat  = accs[47:0];
        if (accs > ACC_MAX)
        begin
            acc_clip = 1'b1;
            acc_sat  = ACC_MAX[47:0];
        end
        else if (accs < -ACC_MAX)
        begin
            acc_clip = 1'b1;
            acc_sat  = 48'(-ACC_MAX);
        end
    end

    always_ff @(posedge clk)
    begin
        case (cmd)
            CMD_LOAD:
            begin
                rs_reg  <= range_start;
                re_reg  <= range_end;
                n_reg   <= step_count;
                sel_reg <= func_select;
            end
            CMD_CHECK:
            begin
                quo_reg  <= {diff_mag, {FRAC_BITS{1'b0}}};
                drem_reg <= 16'd0;
                dcnt_reg <= 6'd0;
                dneg_reg <= diff_s[16];
                area_reg <= 32'sd0;
                sat_reg  <= 1'b0;
                bad_reg  <= sel_reg >= NUM_INTEGRANDS;
            end
            CMD_DIV_STEP:
            begin
                drem_reg <= div_ge ? div_sub[15:0] : div_trial[15:0];
                quo_reg  <= {quo_reg[38:0], div_ge};
                dcnt_reg <= dcnt_reg + 6'd1;
            end
            CMD_DIV_FIX:
            begin
                dx_reg    <= dneg_reg ? -$signed({1'b0, quo_reg}) : $signed({1'b0, quo_reg});
                x_reg     <= {{2{rs_reg[15]}}, rs_reg, {FRAC_BITS{1'b0}}};
                acc_reg   <= 48'sd0;
                cnt_reg   <= 16'd0;
                first_reg <= 1'b1;
            end
            CMD_EVAL:
            begin
                v_reg    <= 35'sd0;
                red_reg  <= xabs;
                rcnt_reg <= 4'd15;
            end
            CMD_RED_STEP:
            begin
                if (red_ge)
                    red_reg <= red_reg - red_cmp[47:0];
                rcnt_reg <= rcnt_reg - 4'd1;
            end
            CMD_RED_FIX:
            begin
                cx_reg <= CORDIC_GAIN;
                cy_reg <= 35'sd0;
                z_reg  <= rf;
                ci_reg <= 5'd0;
            end
            CMD_CORDIC:
            begin
                if (!z_reg[34])
                begin
                    cx_reg <= cx_reg - sy;
                    cy_reg <= cy_reg + sx;
                    z_reg  <= z_reg - at;
                end
                else
                begin
                    cx_reg <= cx_reg + sy;
                    cy_reg <= cy_reg - sx;
                    z_reg  <= z_reg + at;
                end
                ci_reg <= ci_reg + 5'd1;
            end
            CMD_SINE_OUT:    v_reg <= cy_reg;
            CMD_GAUSS_SQ:    prod_reg <= mul_a * mul_b;
            CMD_GAUSS_T:     t_reg <= {7'd0, prod_reg[63:23]};
            CMD_DECAY_T:     t_reg <= t_decay;
            CMD_EXP_INIT:
            begin
                kr_reg <= t_reg[34:0];
                k_reg  <= 5'd0;
                kb_reg <= 3'd4;
                e_reg  <= 31'd0;
            end
            CMD_EXP_K:
            begin
                if (kr_reg >= k_cmp)
                begin
                    kr_reg <= kr_reg - k_cmp;
                    k_reg  <= k_reg | (5'd1 << kb_reg);
                end
                kb_reg <= kb_reg - 3'd1;
            end
            CMD_EXP_PREP:
            begin
                u_reg  <= 31'(LN2_Q - kr_reg);
                y_reg  <= 33'(ONE_Q);
                ei_reg <= 5'd1;
            end
            CMD_EXP_LOOP:
            begin
                // take each factor as often as it fits before moving on
                if (fit)
                begin
                    u_reg <= u_reg - ln_i;
                    y_reg <= y_reg + (y_reg >> ei_reg);
                end
                else if (ei_reg != 5'd30)
                begin
                    ei_reg <= ei_reg + 5'd1;
                end
            end
            CMD_EXP_OUT:     e_reg <= e_round[30:0];
            CMD_GAUSS_SCALE: prod_reg <= mul_a * mul_b;
            CMD_GAUSS_OUT:   v_reg <= $signed({1'b0, gauss_rnd[63:30]}) ;
            CMD_DECAY_OUT:
            begin
                if (lt_one)
                    v_reg <= $signed(ONE_Q[34:0]) - $signed({4'd0, e_reg});
                else
                    v_reg <= $signed({4'd0, e_reg});
            end
            CMD_POST:
            begin
                if (first_reg)
                begin
                    left_reg  <= samp;
                    first_reg <= 1'b0;
                    x_reg     <= x_reg + 42'(dx_reg);
                end
                else
                begin
                    samp_reg <= samp;
                end
            end
            CMD_TERM_LO:     prod_reg <= mul_a * mul_b;
            CMD_TERM_HI:
            begin
                lo_reg   <= prod_reg[63:25];
                prod_reg <= mul_a * mul_b;
            end
            CMD_TERM_ACC:
            begin
                acc_reg  <= acc_sat;
                sat_reg  <= sat_reg | acc_clip;
                left_reg <= samp_reg;
                cnt_reg  <= cnt_reg + 16'd1;
                x_reg    <= x_reg + 42'(dx_reg);
            end
            CMD_FINAL:
            begin
                bad_reg <= 1'b0;
                if (acc_reg > OUT_MAX)
                begin
                    area_reg <= OUT_MAX[31:0];
                    sat_reg  <= 1'b1;
                end
                else if (acc_reg < OUT_MIN)
                begin
                    area_reg <= OUT_MIN[31:0];
                    sat_reg  <= 1'b1;
                end
                else
                begin
                    area_reg <= acc_reg[31:0];
                end
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        status.bad_sel     = sel_reg >= NUM_INTEGRANDS;
        status.zero_n      = n_reg == 16'd0;
        status.div_last    = dcnt_reg == 6'd39;
        status.red_last    = rcnt_reg == 4'd0;
        status.cordic_last = ci_reg == 5'd30;
        status.exp_big     = t_reg >= EXP_LIMIT;
        status.k_last      = kb_reg == 3'd0;
        status.exp_exit    = !fit && ei_reg == 5'd30;
        status.gauss_far   = xabs[47:34] != '0;
        status.x_neg       = x_reg[41];
        status.first       = first_reg;
        status.slice_last  = (cnt_reg + 16'd1) == n_reg;
        status.sel         = sel_reg;
    end

    assign area       = area_reg;
    assign saturated  = sat_reg;
    assign bad_select = bad_reg;

endmodule

>>> tb/trapint_checker.sv
// job checker for the trapezoid integrator: predicts each area and compares results
`timescale 1ns / 1ps

module trapint_checker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic               busy,
    input  logic               done,
    input  logic signed [15:0] range_start,
    input  logic signed [15:0] range_end,
    input  logic [15:0]        step_count,
    input  logic [1:0]         func_select,
    input  logic signed [31:0] area,
    input  logic               saturated,
    input  logic               bad_select,
    output int                 errors,
    output int                 pending
);
    import trapint_pkg::*;

    localparam longint ONE = 64'sd1 <<< IQ;
    localparam longint PI_L = 64'sd3373259426;
    localparam longint HALF_PI_L = 64'sd1686629713;
    localparam longint TWO_PI_L = 64'sd6746518852;
    localparam longint LN2_L = 64'sd744261118;
    localparam longint GAIN_L = 64'sd652032874;
    localparam longint INV_SQRT_L = 64'sd428361012;
    localparam longint SUM_LIMIT = (64'sd1 <<< 47) - 64'sd1;
    localparam longint Q824_MAX = 64'sd2147483647;
    localparam longint Q824_MIN = -64'sd2147483648;

    typedef struct packed {
        logic signed [31:0] area;
        logic               saturated;
        logic               bad_select;
    } job_result_t;

    job_result_t expected_areas[$];
    longint log_steps[31];
    longint arctan_steps[31];

    assign pending = expected_areas.size();

    initial
    begin
        longint acc_sum;
        longint piece;
        arctan_steps = '{64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6,
                         64'h03FEAB76, 64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55,
                         64'h003FFFEA, 64'h001FFFFD, 64'h000FFFFF, 64'h0007FFFF,
                         64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF, 64'h00007FFF,
                         64'h00003FFF, 64'h00001FFF, 64'h00000FFF, 64'h000007FF,
                         64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F,
                         64'h0000003F, 64'h0000001F, 64'h0000000F, 64'h00000008,
                         64'h00000004, 64'h00000002, 64'h00000001};
        log_steps[0] = 0;
        // ln(1+2^-i) from the alternating series at 60 fraction bits
        for (int i = 1; i <= 30; i++)
        begin
            acc_sum = 0;
            for (int k = 1; i * k <= 60; k++)
            begin
                piece = (64'sd1 <<< (60 - i * k)) / k;
                acc_sum = (k % 2 == 1) ? acc_sum + piece : acc_sum - piece;
            end
            log_steps[i] = (acc_sum + (64'sd1 <<< 29)) >>> 30;
        end
    end

    function automatic longint round_shift(longint v, int s);
        longint half;
        if (s <= 0)
            return v;
        half = 64'sd1 <<< (s - 1);
        if (v >= 0)
            return (v + half) >>> s;
        return -(((-v) + half) >>> s);
    endfunction

    function automatic longint exp_decay(longint t);
        longint k;
        longint u;
        longint y;
        if (t < 0)
            t = 0;
        k = t / LN2_L;
        if (k >= 31)
            return 0;
        u = LN2_L - (t - k * LN2_L);
        y = ONE;
        for (int i = 1; i <= 30; i++)
        begin
            while (u >= log_steps[i])
            begin
                u -= log_steps[i];
                y += y >>> i;
            end
        end
        return round_shift(y, int'(k) + 1);
    endfunction

    function automatic longint cordic_sine(longint xq);
        longint r;
        longint cx;
        longint cy;
        longint nx;
        r = xq % TWO_PI_L;
        cx = GAIN_L;
        cy = 0;
        if (r < 0)
            r += TWO_PI_L;
        if (r > PI_L)
            r -= TWO_PI_L;
        if (r > HALF_PI_L)
            r = PI_L - r;
        else if (r < -HALF_PI_L)
            r = -PI_L - r;
        for (int i = 0; i < 31; i++)
        begin
            if (r >= 0)
            begin
                nx = cx - (cy >>> i);
                cy = cy + (cx >>> i);
                r -= arctan_steps[i];
            end
            else
            begin
                nx = cx + (cy >>> i);
                cy = cy - (cx >>> i);
                r += arctan_steps[i];
            end
            cx = nx;
        end
        return cy;
    endfunction

    function automatic longint normal_density(longint xq);
        longint a;
        longint s;
        longint g;
        a = (xq < 0) ? -xq : xq;
        if (a >= (64'sd16 <<< IQ))
            return 0;
        s = a >>> 4;
        g = exp_decay((s * s) >>> 23);
        return (g * INV_SQRT_L + (64'sd1 <<< 29)) >>> IQ;
    endfunction

    function automatic longint charge_curve(longint xq);
        if (xq < 0)
            return 0;
        if (xq < ONE)
            return ONE - exp_decay(5 * xq);
        return exp_decay(xq - ONE);
    endfunction

    function automatic longint sample_at(logic [1:0] sel, longint xf);
        longint xq;
        longint v;
        longint lim;
        xq = xf <<< XQ_SHIFT;
        if (sel == SEL_SINE)
            v = cordic_sine(xq);
        else if (sel == SEL_GAUSS)
            v = normal_density(xq);
        else
            v = charge_curve(xq);
        v = round_shift(v, XQ_SHIFT);
        lim = 64'sd1 <<< FRAC_BITS;
        if (v > lim)
            v = lim;
        if (v < -lim)
            v = -lim;
        return v;
    endfunction

    function automatic longint trapezoid_piece(longint dx, longint s);
        logic neg;
        longint unsigned ua;
        longint unsigned us;
        longint unsigned mag;
        neg = (dx < 0) != (s < 0);
        ua = (dx < 0) ? -dx : dx;
        us = (s < 0) ? -s : s;
        mag = (((ua >> 32) * us) << (32 - FRAC_BITS - 1))
            + (((ua & 64'hFFFFFFFF) * us) >> (FRAC_BITS + 1));
        return neg ? -longint'(mag) : longint'(mag);
    endfunction

    function automatic job_result_t integrate_job(logic signed [15:0] lo,
                                                  logic signed [15:0] hi,
                                                  logic [15:0] n, logic [1:0] sel);
        job_result_t res;
        longint x0;
        longint dx;
        longint left;
        longint right;
        longint sum;
        res = '0;
        if (sel >= NUM_INTEGRANDS)
        begin
            res.bad_select = 1'b1;
            return res;
        end
        if (n == 0)
            return res;
        x0 = longint'(lo) <<< FRAC_BITS;
        dx = ((longint'(hi) - longint'(lo)) <<< FRAC_BITS) / longint'(n);
        left = sample_at(sel, x0);
        sum = 0;
        for (longint i = 1; i <= longint'(n); i++)
        begin
            right = sample_at(sel, x0 + i * dx);
            sum += trapezoid_piece(dx, left + right);
            if (sum > SUM_LIMIT)
            begin
                sum = SUM_LIMIT;
                res.saturated = 1'b1;
            end
            if (sum < -SUM_LIMIT)
            begin
                sum = -SUM_LIMIT;
                res.saturated = 1'b1;
            end
            left = right;
        end
        if (sum > Q824_MAX)
        begin
            sum = Q824_MAX;
            res.saturated = 1'b1;
        end
        if (sum < Q824_MIN)
        begin
            sum = Q824_MIN;
            res.saturated = 1'b1;
        end
        res.area = sum[31:0];
        return res;
    endfunction

    always @(posedge clk)
    begin
        job_result_t want;
        if (!rst_n)
        begin
            errors = 0;
        end
        else
        begin
            if (done)
            begin
                if (expected_areas.size() == 0)
                begin
                    $error("result with no job outstanding: area %0d", area);
                    errors++;
                end
                else
                begin
                    want = expected_areas.pop_front();
                    if (area !== want.area)
                    begin
                        $error("area: expected %0d, got %0d", want.area, area);
                        errors++;
                    end
                    if (saturated !== want.saturated)
                    begin
                        $error("saturated: expected %0b, got %0b", want.saturated, saturated);
                        errors++;
                    end
                    if (bad_select !== want.bad_select)
                    begin
                        $error("bad_select: expected %0b, got %0b",
                               want.bad_select, bad_select);
                        errors++;
                    end
                end
            end
            if (start && !busy)
                expected_areas.push_back(integrate_job(range_start, range_end,
                                                       step_count, func_select));
        end
    end

endmodule

>>> tb/testbench.sv
// stimulus, watchdog and verdict for the trapezoid integrator
`timescale 1ns / 1ps

module testbench;
    import trapint_pkg::*;

    localparam logic [1:0] SEL_DECAY = NUM_INTEGRANDS - 2'd1;
    localparam logic [1:0] SEL_NONE = NUM_INTEGRANDS;
    localparam int STALL_LIMIT = 20000000;

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    logic               done;
    logic signed [15:0] range_start;
    logic signed [15:0] range_end;
    logic [15:0]        step_count;
    logic [1:0]         func_select;
    logic signed [31:0] area;
    logic               saturated;
    logic               bad_select;
    int                 errors;
    int                 pending;
    int                 quiet_cycles;
    int                 idle_pct;

    trapezoid_integrator_core uut (.*);

    trapint_checker u_checker (.*);

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // watchdog: cycles with neither a job taken nor a result
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("FAIL trapezoid_integrator_core");
            $finish;
        end
    end

    task automatic issue_job(logic signed [15:0] lo, logic signed [15:0] hi,
                             logic [15:0] n, logic [1:0] sel);
        start <= 1'b1;
        range_start <= lo;
        range_end <= hi;
        step_count <= n;
        func_select <= sel;
        do
            @(posedge clk);
        while (busy);
        // random gaps between items
        if ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < idle_pct);
        end
    endtask

    task automatic random_job();
        logic signed [15:0] lo;
        logic signed [15:0] hi;
        logic [15:0] n;
        logic [1:0] sel;
        lo = 16'($urandom);
        hi = ($urandom_range(1)) ? 16'($urandom) : lo + $signed(16'($urandom_range(40))) - 16'sd20;
        sel = ($urandom_range(9) == 0) ? SEL_NONE : 2'($urandom_range(2));
        case ($urandom_range(9))
            0:       n = 16'($urandom_range(1000));
            1:       n = 16'd0;
            default: n = 16'($urandom_range(40));
        endcase
        issue_job(lo, hi, n, sel);
    endtask

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        range_start = '0;
        range_end = '0;
        step_count = '0;
        func_select = SEL_SINE;
        idle_pct = 33;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        issue_job(16'sd0, 16'sd0, 16'd0, SEL_SINE);
        issue_job(-16'sd32768, 16'sd32767, 16'd8, SEL_SINE);
        issue_job(16'sd32767, -16'sd32768, 16'd8, SEL_GAUSS);
        issue_job(16'sd3, -16'sd3, 16'd12, SEL_SINE);
        issue_job(16'sd0, 16'sd0, 16'd10, SEL_SINE);
        issue_job(16'sd0, 16'sd1, 16'd1, SEL_DECAY);
        issue_job(-16'sd1, 16'sd3, 16'd16, SEL_DECAY);
        issue_job(16'sd1, 16'sd32767, 16'd1, SEL_DECAY);
        issue_job(16'sd32767, 16'sd1, 16'd1, SEL_DECAY);
        issue_job(-16'sd5, 16'sd5, 16'd64, SEL_GAUSS);
        issue_job(-16'sd16, 16'sd16, 16'd32, SEL_GAUSS);
        issue_job(16'sd0, 16'sd3, 16'd0, SEL_NONE);
        issue_job(16'sd5, -16'sd5, 16'd100, SEL_NONE);
        issue_job(16'sd0, 16'sd6, 16'hFFFF, SEL_GAUSS);

        for (int i = 0; i < 34; i++)
            random_job();
        idle_pct = 83;
        for (int i = 0; i < 33; i++)
            random_job();
        idle_pct = 0;
        for (int i = 0; i < 33; i++)
            random_job();
        start <= 1'b0;
        // let the checker record the last accepted item first
        @(posedge clk);

        while (pending != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (errors == 0)
            $display("PASS trapezoid_integrator_core");
        else
            $display("FAIL trapezoid_integrator_core");
        $finish;
    end

endmodule
